### rtl/core/document_feature_counter_macros.svh
// ----------------------------------------------------------------------------
// document feature counter assertion macros
// clocked assertion helpers shared by the rtl files of the counter
// ----------------------------------------------------------------------------
`ifndef DOCUMENT_FEATURE_COUNTER_MACROS_SVH
`define DOCUMENT_FEATURE_COUNTER_MACROS_SVH

`ifndef SYNTH
`define DFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
`define DFC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);
`else
`define DFC_ASSERT(lbl, prop, msg)
`define DFC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/dfc_pkg.sv
// ----------------------------------------------------------------------------
// document feature counter package
// shared types, character codes, keyword table and helper functions
// ----------------------------------------------------------------------------
package dfc_pkg;

	localparam int COUNT_WIDTH  = 32;
	localparam int REPORT_WIDTH = 32;
	localparam int CNT_SLOTS    = 7;
	localparam int OUT_WIDTH    = CNT_SLOTS * REPORT_WIDTH;

	localparam int CNT_LINE   = 0;
	localparam int CNT_HEADER = 1;
	localparam int CNT_OPEN   = 2;
	localparam int CNT_DONE   = 3;
	localparam int CNT_WORD   = 4;
	localparam int CNT_ENTITY = 5;
	localparam int CNT_ARROW  = 6;

	typedef logic [COUNT_WIDTH-1:0]                count_t;
	typedef logic [REPORT_WIDTH-1:0]               report_t;
	typedef logic [CNT_SLOTS-1:0][COUNT_WIDTH-1:0] count_vec_t;
	typedef logic [7:0]                            byte_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic MODE_MARKDOWN = 1'b0;
	localparam logic MODE_PLANTUML = 1'b1;

	localparam byte_t CH_TAB     = 8'h09;
	localparam byte_t CH_LF      = 8'h0A;
	localparam byte_t CH_CR      = 8'h0D;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_HASH    = 8'h23;
	localparam byte_t CH_DASH    = 8'h2D;
	localparam byte_t CH_DOT     = 8'h2E;
	localparam byte_t CH_LT      = 8'h3C;
	localparam byte_t CH_GT      = 8'h3E;
	localparam byte_t CH_UPPER_A = 8'h41;
	localparam byte_t CH_UPPER_X = 8'h58;
	localparam byte_t CH_UPPER_Z = 8'h5A;
	localparam byte_t CH_LBRACK  = 8'h5B;
	localparam byte_t CH_RBRACK  = 8'h5D;
	localparam byte_t CH_LOWER_X = 8'h78;
	localparam byte_t CASE_SHIFT = 8'h20;

	localparam logic [2:0] HASH_RUN_MAX  = 3'd7;
	localparam logic [2:0] HDR_MAX_LEVEL = 3'd6;

	typedef enum logic [1:0] {
		HDR_COUNTING,
		HDR_YES,
		HDR_NO
	} hdr_phase_t;

	typedef enum logic [2:0] {
		TSK_LEAD,
		TSK_GAP,
		TSK_MARK,
		TSK_CLOSE,
		TSK_YES,
		TSK_NO
	} task_phase_t;

	localparam logic [1:0] TASK_MARK_NONE = 2'd0;
	localparam logic [1:0] TASK_MARK_OPEN = 2'd1;
	localparam logic [1:0] TASK_MARK_DONE = 2'd2;

	typedef enum logic [1:0] {
		KW_LEAD,
		KW_MATCH,
		KW_YES,
		KW_NO
	} kw_phase_t;

	localparam int KW_COUNT   = 7;
	localparam int KW_MAX_LEN = 9;
	localparam int KW_TEXT_W  = KW_MAX_LEN * 8;

	typedef logic [KW_TEXT_W-1:0] kw_text_t;
	typedef logic [3:0]           kw_pos_t;
	typedef logic [KW_COUNT-1:0]  kw_mask_t;

	localparam kw_pos_t  KW_POS_MAX = 4'd15;
	localparam kw_mask_t KW_ALL     = '1;

	// words stored left justified, first character in the top byte
	localparam kw_text_t KW_WORDS [KW_COUNT] = '{
		{"class", 32'h0},
		{"component"},
		{"actor", 32'h0},
		{"usecase", 16'h0},
		{"state", 32'h0},
		{"node", 40'h0},
		{"interface"}
	};

	localparam kw_pos_t KW_LENS [KW_COUNT] = '{
		4'd5, 4'd9, 4'd5, 4'd7, 4'd5, 4'd4, 4'd9
	};

	typedef struct packed {
		logic line;
		logic header;
		logic open_task;
		logic done_task;
		logic word;
		logic entity;
		logic arrow;
	} bump_t;

	function automatic logic is_ws(input byte_t c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic byte_t fold(input byte_t c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? byte_t'(c + CASE_SHIFT) : c;
	endfunction

	function automatic byte_t kw_char(input kw_text_t w, input kw_pos_t pos);
		byte_t r;
		r = '0;
		for (int i = 0; i < KW_MAX_LEN; i++) begin
			if (pos == kw_pos_t'(i)) begin
				r = w[KW_TEXT_W-1-8*i -: 8];
			end
		end
		return r;
	endfunction

	function automatic report_t report(input count_t v);
		return (v > count_t'({REPORT_WIDTH{1'b1}})) ? '1 : report_t'(v);
	endfunction

endpackage

### rtl/core/dfc_line_scan.sv
// ----------------------------------------------------------------------------
// document feature counter line scanner
// per-line feature trackers; turns each item into counter increments
// ----------------------------------------------------------------------------
`include "document_feature_counter_macros.svh"

module dfc_line_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           kind,
	input  dfc_pkg::byte_t byte_value,
	input  logic           doc_mode,
	output dfc_pkg::bump_t bump
);

	logic                 line_started_q, line_started_n;
	logic [2:0]           hash_run_q, hash_run_n;
	dfc_pkg::hdr_phase_t  hdr_phase_q, hdr_phase_n;
	dfc_pkg::task_phase_t task_phase_q, task_phase_n;
	logic [1:0]           task_mark_q, task_mark_n;
	logic                 in_word_q, in_word_n;
	dfc_pkg::kw_mask_t    kw_alive_q, kw_alive_n;
	dfc_pkg::kw_pos_t     kw_pos_q, kw_pos_n;
	dfc_pkg::kw_phase_t   kw_phase_q, kw_phase_n;
	logic                 prev_dd_q, prev_dd_n;
	logic                 prev_lt_q, prev_lt_n;

	logic              ws;
	logic              dash_or_dot;
	dfc_pkg::byte_t    lc;
	dfc_pkg::bump_t    close_b;
	logic              hash_ok;
	logic [2:0]        hash_inc;
	dfc_pkg::kw_mask_t kw_keep;
	logic              kw_hit;
	logic              md;

	always_comb begin
		ws          = dfc_pkg::is_ws(byte_value);
		lc          = dfc_pkg::fold(byte_value);
		dash_or_dot = (byte_value == dfc_pkg::CH_DASH) || (byte_value == dfc_pkg::CH_DOT);
		md          = (doc_mode == dfc_pkg::MODE_MARKDOWN);
		hash_ok     = (hash_run_q != 3'd0) && (hash_run_q <= dfc_pkg::HDR_MAX_LEVEL);
		hash_inc    = (hash_run_q < dfc_pkg::HASH_RUN_MAX) ? hash_run_q + 3'd1 : hash_run_q;

		// increments owed when the current line closes
		close_b           = '0;
		close_b.line      = 1'b1;
		close_b.header    = md && ((hdr_phase_q == dfc_pkg::HDR_YES) ||
			((hdr_phase_q == dfc_pkg::HDR_COUNTING) && hash_ok));
		close_b.open_task = md && (task_phase_q == dfc_pkg::TSK_YES) &&
			(task_mark_q == dfc_pkg::TASK_MARK_OPEN);
		close_b.done_task = md && (task_phase_q == dfc_pkg::TSK_YES) &&
			(task_mark_q == dfc_pkg::TASK_MARK_DONE);
		close_b.entity    = !md && (kw_phase_q == dfc_pkg::KW_YES);

		// keyword candidates, one lane per word
		kw_keep = '0;
		kw_hit  = 1'b0;
		for (int k = 0; k < dfc_pkg::KW_COUNT; k++) begin
			if (kw_pos_q < dfc_pkg::KW_LENS[k]) begin
				kw_keep[k] = kw_alive_q[k] &&
					(lc == dfc_pkg::kw_char(dfc_pkg::KW_WORDS[k], kw_pos_q));
			end else begin
				kw_hit = kw_hit || (kw_alive_q[k] && ws);
			end
		end

		line_started_n = line_started_q;
		hash_run_n     = hash_run_q;
		hdr_phase_n    = hdr_phase_q;
		task_phase_n   = task_phase_q;
		task_mark_n    = task_mark_q;
		in_word_n      = in_word_q;
		kw_alive_n     = kw_alive_q;
		kw_pos_n       = kw_pos_q;
		kw_phase_n     = kw_phase_q;
		prev_dd_n      = prev_dd_q;
		prev_lt_n      = prev_lt_q;
		bump           = '0;

		if (kind == dfc_pkg::KIND_END || byte_value == dfc_pkg::CH_LF) begin
			if (kind == dfc_pkg::KIND_END) begin
				in_word_n = 1'b0;
				if (line_started_q) begin
					bump = close_b;
				end
			end else begin
				in_word_n = 1'b0;
				bump      = close_b;
			end
			line_started_n = 1'b0;
			hash_run_n     = '0;
			hdr_phase_n    = dfc_pkg::HDR_COUNTING;
			task_phase_n   = dfc_pkg::TSK_LEAD;
			task_mark_n    = dfc_pkg::TASK_MARK_NONE;
			kw_alive_n     = dfc_pkg::KW_ALL;
			kw_pos_n       = '0;
			kw_phase_n     = dfc_pkg::KW_LEAD;
			prev_dd_n      = 1'b0;
			prev_lt_n      = 1'b0;
		end else begin
			in_word_n      = !ws;
			bump.word      = !ws && !in_word_q && md;
			line_started_n = 1'b1;

			// atx header
			if (hdr_phase_q == dfc_pkg::HDR_COUNTING) begin
				if (byte_value == dfc_pkg::CH_HASH) begin
					hash_run_n = hash_inc;
					if (hash_inc > dfc_pkg::HDR_MAX_LEVEL) begin
						hdr_phase_n = dfc_pkg::HDR_NO;
					end
				end else if (hash_ok && ws) begin
					hdr_phase_n = dfc_pkg::HDR_YES;
				end else begin
					hdr_phase_n = dfc_pkg::HDR_NO;
				end
			end

			// task box
			unique case (task_phase_q)
				dfc_pkg::TSK_LEAD: begin
					if (byte_value == dfc_pkg::CH_DASH) begin
						task_phase_n = dfc_pkg::TSK_GAP;
					end else if (!ws) begin
						task_phase_n = dfc_pkg::TSK_NO;
					end
				end
				dfc_pkg::TSK_GAP: begin
					if (byte_value == dfc_pkg::CH_LBRACK) begin
						task_phase_n = dfc_pkg::TSK_MARK;
					end else if (byte_value != dfc_pkg::CH_SPACE &&
						byte_value != dfc_pkg::CH_TAB) begin
						task_phase_n = dfc_pkg::TSK_NO;
					end
				end
				dfc_pkg::TSK_MARK: begin
					if (byte_value == dfc_pkg::CH_SPACE) begin
						task_mark_n  = dfc_pkg::TASK_MARK_OPEN;
						task_phase_n = dfc_pkg::TSK_CLOSE;
					end else if (byte_value == dfc_pkg::CH_LOWER_X ||
						byte_value == dfc_pkg::CH_UPPER_X) begin
						task_mark_n  = dfc_pkg::TASK_MARK_DONE;
						task_phase_n = dfc_pkg::TSK_CLOSE;
					end else begin
						task_phase_n = dfc_pkg::TSK_NO;
					end
				end
				dfc_pkg::TSK_CLOSE: begin
					task_phase_n = (byte_value == dfc_pkg::CH_RBRACK) ?
						dfc_pkg::TSK_YES : dfc_pkg::TSK_NO;
				end
				default: begin
				end
			endcase

			// entity keyword
			if ((kw_phase_q == dfc_pkg::KW_MATCH) ||
				(kw_phase_q == dfc_pkg::KW_LEAD && !ws)) begin
				if (kw_hit) begin
					kw_phase_n = dfc_pkg::KW_YES;
				end else begin
					kw_alive_n = kw_keep;
					kw_phase_n = (kw_keep == '0) ? dfc_pkg::KW_NO : dfc_pkg::KW_MATCH;
					kw_pos_n   = (kw_pos_q < dfc_pkg::KW_POS_MAX) ? kw_pos_q + 4'd1 : kw_pos_q;
				end
			end

			// arrow heads
			bump.arrow = !md && (((byte_value == dfc_pkg::CH_GT) && prev_dd_q) ||
				(dash_or_dot && prev_lt_q));
			prev_dd_n  = dash_or_dot;
			prev_lt_n  = (byte_value == dfc_pkg::CH_LT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_started_q <= 1'b0;
			hash_run_q     <= '0;
			hdr_phase_q    <= dfc_pkg::HDR_COUNTING;
			task_phase_q   <= dfc_pkg::TSK_LEAD;
			task_mark_q    <= dfc_pkg::TASK_MARK_NONE;
			in_word_q      <= 1'b0;
			kw_alive_q     <= dfc_pkg::KW_ALL;
			kw_pos_q       <= '0;
			kw_phase_q     <= dfc_pkg::KW_LEAD;
			prev_dd_q      <= 1'b0;
			prev_lt_q      <= 1'b0;
		end else if (step) begin
			line_started_q <= line_started_n;
			hash_run_q     <= hash_run_n;
			hdr_phase_q    <= hdr_phase_n;
			task_phase_q   <= task_phase_n;
			task_mark_q    <= task_mark_n;
			in_word_q      <= in_word_n;
			kw_alive_q     <= kw_alive_n;
			kw_pos_q       <= kw_pos_n;
			kw_phase_q     <= kw_phase_n;
			prev_dd_q      <= prev_dd_n;
			prev_lt_q      <= prev_lt_n;
		end
	end

	`DFC_ASSERT_NEVER(a_kw_match_alive, kw_phase_q == dfc_pkg::KW_MATCH && kw_alive_q == '0, "keyword match with no live candidate")
	`DFC_ASSERT(a_end_clears_line, step && kind == dfc_pkg::KIND_END |=> !line_started_q && !in_word_q, "end transfer left line state set")

endmodule

### rtl/core/dfc_counters.sv
// ----------------------------------------------------------------------------
// document feature counter totals
// seven saturating counters, cleared after each document
// ----------------------------------------------------------------------------
`include "document_feature_counter_macros.svh"

module dfc_counters (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                clear,
	input  dfc_pkg::bump_t      bump,
	output dfc_pkg::count_vec_t totals
);

	dfc_pkg::count_vec_t              counts_q;
	logic [dfc_pkg::CNT_SLOTS-1:0]   inc;

	always_comb begin
		inc                      = '0;
		inc[dfc_pkg::CNT_LINE]   = bump.line;
		inc[dfc_pkg::CNT_HEADER] = bump.header;
		inc[dfc_pkg::CNT_OPEN]   = bump.open_task;
		inc[dfc_pkg::CNT_DONE]   = bump.done_task;
		inc[dfc_pkg::CNT_WORD]   = bump.word;
		inc[dfc_pkg::CNT_ENTITY] = bump.entity;
		inc[dfc_pkg::CNT_ARROW]  = bump.arrow;
		for (int j = 0; j < dfc_pkg::CNT_SLOTS; j++) begin
			totals[j] = (inc[j] && (counts_q[j] != '1)) ?
				counts_q[j] + dfc_pkg::count_t'(1) : counts_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (step) begin
			counts_q <= clear ? '0 : totals;
		end
	end

	`DFC_ASSERT(a_clear_zero, step && clear |=> counts_q == '0, "counters not cleared after end transfer")

endmodule

### rtl/core/document_feature_counter.sv
// ----------------------------------------------------------------------------
// document feature counter
// counts lines, headers, task boxes, words, entities and arrows of a document
// ----------------------------------------------------------------------------
// one item per cycle while no end item waits; a byte item never stalls the input
// an end item's totals reach the output through the input and output registers
// an end item waits in the input register only while an earlier result is not taken
// reset clears all counters, line state and doc_mode (markdown) at once
`include "document_feature_counter_macros.svh"

module document_feature_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,       // doc_mode
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,   // byte_value
	input  logic                             s_axis_tuser,   // kind
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// line_total, header_total, open_task_total, done_task_total,
	// word_total, entity_total, arrow_total, 32 bits each
	output logic [dfc_pkg::OUT_WIDTH-1:0]    m_axis_tdata
);

	logic                          doc_mode_q;
	logic                          valid_s1;
	logic                          kind_s1;
	dfc_pkg::byte_t                byte_s1;
	logic                          m_valid_q;
	logic [dfc_pkg::OUT_WIDTH-1:0] m_data_q;
	logic                          out_free;
	logic                          advance;
	logic                          is_end;
	dfc_pkg::bump_t                bump;
	dfc_pkg::count_vec_t           totals;

	assign cfg_ready     = 1'b1;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign is_end        = (kind_s1 == dfc_pkg::KIND_END);
	assign advance       = valid_s1 && (!is_end || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_mode_q <= dfc_pkg::MODE_MARKDOWN;
		end else if (cfg_valid && cfg_ready) begin
			doc_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	dfc_line_scan u_line_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.kind       (kind_s1),
		.byte_value (byte_s1),
		.doc_mode   (doc_mode_q),
		.bump       (bump)
	);

	dfc_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.clear  (is_end),
		.bump   (bump),
		.totals (totals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			for (int j = 0; j < dfc_pkg::CNT_SLOTS; j++) begin
				m_data_q[j*dfc_pkg::REPORT_WIDTH +: dfc_pkg::REPORT_WIDTH] <=
					dfc_pkg::report(totals[j]);
			end
		end
	end

	`DFC_ASSERT(a_end_to_out, advance && is_end |=> m_axis_tvalid, "end transfer produced no result")
	`DFC_ASSERT(a_out_from_end, $rose(m_axis_tvalid) |-> $past(advance && is_end), "result without end transfer")
	`DFC_ASSERT_NEVER(a_stall_cause, valid_s1 && !advance && !(is_end && m_valid_q && !m_axis_tready), "input stalled without a blocked result")

endmodule

### tb/tb_document_feature_counter.sv
// ----------------------------------------------------------------------------
// document feature counter testbench
// streams markdown and plantuml style documents byte by byte with random
// gaps and output stalls, predicts the totals of every random end transfer
// (directed ones from a table), compares each result transfer field by field
// ----------------------------------------------------------------------------
module tb_document_feature_counter;
	import dfc_pkg::*;

	typedef struct packed {
		report_t arrow_total;
		report_t entity_total;
		report_t word_total;
		report_t done_task_total;
		report_t open_task_total;
		report_t header_total;
		report_t line_total;
	} totals_t;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_END,
		OP_MODE
	} row_op_t;

	typedef struct packed {
		row_op_t op;
		byte_t   val;
		logic    typed;
		totals_t exp;
	} dir_row_t;

	localparam int DIR_ROWS     = 26;
	localparam int RANDOM_ITEMS = 1950;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{OP_END,  8'h00,     1'b1, '0},
		'{OP_BYTE, CH_HASH,   1'b0, '0},
		'{OP_BYTE, CH_SPACE,  1'b0, '0},
		'{OP_BYTE, 8'h68,     1'b0, '0},
		'{OP_BYTE, CH_LF,     1'b0, '0},
		'{OP_BYTE, CH_DASH,   1'b0, '0},
		'{OP_BYTE, CH_SPACE,  1'b0, '0},
		'{OP_BYTE, CH_LBRACK, 1'b0, '0},
		'{OP_BYTE, CH_LOWER_X, 1'b0, '0},
		'{OP_BYTE, CH_RBRACK, 1'b0, '0},
		'{OP_END,  8'hA5,     1'b1, '{line_total: 2, header_total: 1, done_task_total: 1,
			word_total: 4, default: '0}},
		'{OP_BYTE, 8'hFF,     1'b0, '0},
		'{OP_BYTE, 8'h00,     1'b0, '0},
		'{OP_BYTE, CH_CR,     1'b0, '0},
		'{OP_END,  8'hFF,     1'b1, '{line_total: 1, word_total: 1, default: '0}},
		'{OP_BYTE, CH_LF,     1'b0, '0},
		'{OP_END,  8'h5A,     1'b1, '{line_total: 1, default: '0}},
		'{OP_MODE, {7'd0, MODE_PLANTUML}, 1'b0, '0},
		'{OP_BYTE, 8'h4E,     1'b0, '0},
		'{OP_BYTE, 8'h6F,     1'b0, '0},
		'{OP_BYTE, 8'h44,     1'b0, '0},
		'{OP_BYTE, 8'h65,     1'b0, '0},
		'{OP_BYTE, CH_TAB,    1'b0, '0},
		'{OP_BYTE, CH_LT,     1'b0, '0},
		'{OP_BYTE, CH_DASH,   1'b0, '0},
		'{OP_END,  8'h00,     1'b1, '{line_total: 1, entity_total: 1, arrow_total: 1,
			default: '0}}
	};

	localparam byte_t WS_SET [5]    = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C, CH_CR};
	localparam byte_t PUNCT_SET [9] = '{CH_HASH, CH_DASH, CH_DOT, CH_LT, CH_GT, CH_LBRACK,
		CH_RBRACK, CH_LOWER_X, CH_UPPER_X};
	localparam byte_t ARROW_SET [7] = '{CH_DASH, CH_DOT, CH_LT, CH_GT, CH_SPACE, 8'h61, 8'h3D};

	string kw_names [KW_COUNT] = '{"class", "component", "actor", "usecase", "state", "node",
		"interface"};
	string field_names [CNT_SLOTS] = '{"line_total", "header_total", "open_task_total",
		"done_task_total", "word_total", "entity_total", "arrow_total"};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data      = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_WIDTH-1:0] m_axis_tdata;

	document_feature_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // byte_value
		.s_axis_tuser  (s_axis_tuser),   // kind
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// line_total, header_total, open_task_total, done_task_total,
		// word_total, entity_total, arrow_total
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// document tracking state
	logic        doc_mode_q     = MODE_MARKDOWN;
	logic        line_open      = 1'b0;
	logic [2:0]  hash_count     = '0;
	hdr_phase_t  hdr_ph         = HDR_COUNTING;
	task_phase_t tsk_ph         = TSK_LEAD;
	logic [1:0]  tsk_mark       = TASK_MARK_NONE;
	logic        word_open      = 1'b0;
	kw_mask_t    kw_alive       = KW_ALL;
	kw_pos_t     kw_pos         = '0;
	kw_phase_t   kw_ph          = KW_LEAD;
	logic        after_dash_dot = 1'b0;
	logic        after_lt       = 1'b0;
	count_t      doc_totals [CNT_SLOTS];

	totals_t totals_due [$];
	byte_t   line_buf [$];
	int      mismatches = 0;
	int      items_sent = 0;
	int      burst_left = 0;

	function automatic logic blank(input byte_t c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic void bump_total(input int slot);
		if (doc_totals[slot] != '1) begin
			doc_totals[slot]++;
		end
	endfunction

	function automatic void reset_line_state();
		line_open      = 1'b0;
		hash_count     = '0;
		hdr_ph         = HDR_COUNTING;
		tsk_ph         = TSK_LEAD;
		tsk_mark       = TASK_MARK_NONE;
		kw_alive       = KW_ALL;
		kw_pos         = '0;
		kw_ph          = KW_LEAD;
		after_dash_dot = 1'b0;
		after_lt       = 1'b0;
	endfunction

	function automatic void finish_line();
		bump_total(CNT_LINE);
		if (doc_mode_q == MODE_MARKDOWN) begin
			if (hdr_ph == HDR_YES ||
					(hdr_ph == HDR_COUNTING && hash_count >= 1 && hash_count <= HDR_MAX_LEVEL)) begin
				bump_total(CNT_HEADER);
			end
			if (tsk_ph == TSK_YES && tsk_mark == TASK_MARK_OPEN) begin
				bump_total(CNT_OPEN);
			end else if (tsk_ph == TSK_YES && tsk_mark == TASK_MARK_DONE) begin
				bump_total(CNT_DONE);
			end
		end else if (kw_ph == KW_YES) begin
			bump_total(CNT_ENTITY);
		end
		reset_line_state();
	endfunction

	function automatic void step_header(input byte_t c);
		if (hdr_ph != HDR_COUNTING) begin
			return;
		end
		if (c == CH_HASH) begin
			if (hash_count != HASH_RUN_MAX) begin
				hash_count++;
			end
			if (hash_count > HDR_MAX_LEVEL) begin
				hdr_ph = HDR_NO;
			end
		end else if (hash_count >= 1 && hash_count <= HDR_MAX_LEVEL && blank(c)) begin
			hdr_ph = HDR_YES;
		end else begin
			hdr_ph = HDR_NO;
		end
	endfunction

	function automatic void step_task(input byte_t c);
		case (tsk_ph)
			TSK_LEAD: begin
				if (c == CH_DASH) begin
					tsk_ph = TSK_GAP;
				end else if (!blank(c)) begin
					tsk_ph = TSK_NO;
				end
			end
			TSK_GAP: begin
				if (c == CH_LBRACK) begin
					tsk_ph = TSK_MARK;
				end else if (c != CH_SPACE && c != CH_TAB) begin
					tsk_ph = TSK_NO;
				end
			end
			TSK_MARK: begin
				if (c == CH_SPACE) begin
					tsk_mark = TASK_MARK_OPEN;
					tsk_ph   = TSK_CLOSE;
				end else if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					tsk_mark = TASK_MARK_DONE;
					tsk_ph   = TSK_CLOSE;
				end else begin
					tsk_ph = TSK_NO;
				end
			end
			TSK_CLOSE: begin
				tsk_ph = (c == CH_RBRACK) ? TSK_YES : TSK_NO;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void step_keyword(input byte_t c);
		byte_t    lc;
		logic     hit;
		kw_mask_t still;
		lc    = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? byte_t'(c + CASE_SHIFT) : c;
		hit   = 1'b0;
		still = '0;
		if (kw_ph == KW_LEAD) begin
			if (blank(c)) begin
				return;
			end
			kw_ph = KW_MATCH;
		end
		if (kw_ph != KW_MATCH) begin
			return;
		end
		for (int k = 0; k < KW_COUNT; k++) begin
			if (kw_alive[k]) begin
				if (kw_pos < kw_names[k].len()) begin
					still[k] = (lc == byte_t'(kw_names[k][kw_pos]));
				end else if (blank(c)) begin
					hit = 1'b1;
				end
			end
		end
		if (hit) begin
			kw_ph = KW_YES;
			return;
		end
		kw_alive = still;
		if (still == '0) begin
			kw_ph = KW_NO;
		end
		if (kw_pos != KW_POS_MAX) begin
			kw_pos++;
		end
	endfunction

	// returns 1 when the item closes a document, with its totals
	function automatic logic tally_item(input logic kind, input byte_t c, output totals_t res);
		res = '0;
		if (kind == KIND_END) begin
			if (line_open) begin
				finish_line();
			end
			res.line_total      = doc_totals[CNT_LINE];
			res.header_total    = doc_totals[CNT_HEADER];
			res.open_task_total = doc_totals[CNT_OPEN];
			res.done_task_total = doc_totals[CNT_DONE];
			res.word_total      = doc_totals[CNT_WORD];
			res.entity_total    = doc_totals[CNT_ENTITY];
			res.arrow_total     = doc_totals[CNT_ARROW];
			for (int j = 0; j < CNT_SLOTS; j++) begin
				doc_totals[j] = '0;
			end
			word_open = 1'b0;
			reset_line_state();
			return 1'b1;
		end
		if (blank(c)) begin
			word_open = 1'b0;
		end else if (!word_open) begin
			word_open = 1'b1;
			if (doc_mode_q == MODE_MARKDOWN) begin
				bump_total(CNT_WORD);
			end
		end
		if (c == CH_LF) begin
			finish_line();
			return 1'b0;
		end
		line_open = 1'b1;
		step_header(c);
		step_task(c);
		step_keyword(c);
		if (doc_mode_q == MODE_PLANTUML) begin
			if (c == CH_GT && after_dash_dot) begin
				bump_total(CNT_ARROW);
			end
			if ((c == CH_DASH || c == CH_DOT) && after_lt) begin
				bump_total(CNT_ARROW);
			end
		end
		after_dash_dot = (c == CH_DASH || c == CH_DOT);
		after_lt       = (c == CH_LT);
		return 1'b0;
	endfunction

	task automatic note_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// sender: bursts of random length, random gaps in between
	task automatic push_item(input logic kind, input byte_t val, input logic typed = 1'b0,
			input totals_t typed_exp = '0);
		totals_t res;
		int      gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0: gap = 0;
				3: gap = $urandom_range(5, 20);
				default: gap = $urandom_range(1, 4);
			endcase
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		items_sent++;
		if (tally_item(kind, val, res)) begin
			totals_due.push_back(typed ? typed_exp : res);
		end
	endtask

	// mode writes only once all totals are back and the pipeline has drained
	task automatic set_mode(input logic m);
		s_axis_tvalid <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		doc_mode_q = m;
	endtask

	function automatic byte_t text_byte();
		case ($urandom_range(0, 7))
			0, 1, 2: return byte_t'(8'h61 + $urandom_range(0, 25));
			3: return byte_t'(CH_UPPER_A + $urandom_range(0, 25));
			4: return CH_SPACE;
			5: return WS_SET[$urandom_range(0, 4)];
			6: return PUNCT_SET[$urandom_range(0, 8)];
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_line();
		int    n;
		string kw;
		byte_t ch;
		line_buf.delete();
		case ($urandom_range(0, 5))
			0: begin
				repeat ($urandom_range(0, 8)) line_buf.push_back(CH_HASH);
				case ($urandom_range(0, 2))
					0: line_buf.push_back(WS_SET[$urandom_range(0, 4)]);
					1: line_buf.push_back(byte_t'(8'h61 + $urandom_range(0, 25)));
					default: begin
					end
				endcase
			end
			1: begin
				repeat ($urandom_range(0, 2)) line_buf.push_back(WS_SET[$urandom_range(0, 4)]);
				line_buf.push_back(($urandom_range(0, 7) == 0) ? 8'h2A : CH_DASH);
				repeat ($urandom_range(0, 2)) begin
					if ($urandom_range(0, 9) == 0) begin
						line_buf.push_back(CH_CR);
					end else begin
						line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
					end
				end
				line_buf.push_back(($urandom_range(0, 9) == 0) ? 8'h28 : CH_LBRACK);
				case ($urandom_range(0, 3))
					0: line_buf.push_back(CH_SPACE);
					1: line_buf.push_back(CH_LOWER_X);
					2: line_buf.push_back(CH_UPPER_X);
					default: line_buf.push_back(text_byte());
				endcase
				line_buf.push_back(($urandom_range(0, 5) == 0) ? text_byte() : CH_RBRACK);
			end
			2: begin
				repeat ($urandom_range(0, 2)) line_buf.push_back(WS_SET[$urandom_range(0, 4)]);
				kw = kw_names[$urandom_range(0, KW_COUNT - 1)];
				n  = kw.len() - (($urandom_range(0, 5) == 0) ? 1 : 0);
				for (int i = 0; i < n; i++) begin
					ch = byte_t'(kw[i]);
					if ($urandom_range(0, 1)) begin
						ch = ch - CASE_SHIFT;
					end
					line_buf.push_back(ch);
				end
				case ($urandom_range(0, 3))
					0, 1: line_buf.push_back(WS_SET[$urandom_range(0, 4)]);
					2: line_buf.push_back(byte_t'(8'h61 + $urandom_range(0, 25)));
					default: begin
					end
				endcase
			end
			3: begin
				repeat ($urandom_range(1, 12)) line_buf.push_back(ARROW_SET[$urandom_range(0, 6)]);
			end
			4: begin
			end
			default: begin
				repeat ($urandom_range(0, 8)) line_buf.push_back(byte_t'($urandom_range(0, 255)));
			end
		endcase
		repeat ($urandom_range(0, 8)) line_buf.push_back(text_byte());
	endtask

	// receiver: switches between random stall styles
	int         stall_left  = 0;
	int         stall_style = 0;
	logic [2:0] tick        = '0;

	always @(posedge clk) begin
		tick <= tick + 3'd1;
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left  <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= (tick >= 3'd6);
		endcase
	end

	logic [OUT_WIDTH-1:0] want_bits;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (totals_due.size() == 0) begin
				note_mismatch($sformatf("result with no document pending: %h", m_axis_tdata));
			end else begin
				want_bits = totals_due.pop_front();
				for (int j = 0; j < CNT_SLOTS; j++) begin
					if (m_axis_tdata[REPORT_WIDTH*j +: REPORT_WIDTH] !==
							want_bits[REPORT_WIDTH*j +: REPORT_WIDTH]) begin
						note_mismatch($sformatf("%s got %0d expected %0d", field_names[j],
							m_axis_tdata[REPORT_WIDTH*j +: REPORT_WIDTH],
							want_bits[REPORT_WIDTH*j +: REPORT_WIDTH]));
					end
				end
			end
		end
	end

	initial begin
		int n_lines;
		for (int j = 0; j < CNT_SLOTS; j++) begin
			doc_totals[j] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			case (DIR_TABLE[i].op)
				OP_MODE: set_mode(DIR_TABLE[i].val[0]);
				OP_BYTE: push_item(KIND_BYTE, DIR_TABLE[i].val);
				default: push_item(KIND_END, DIR_TABLE[i].val, DIR_TABLE[i].typed,
					DIR_TABLE[i].exp);
			endcase
		end

		while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				set_mode(1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 14) == 0) begin
				repeat ($urandom_range(0, 30)) push_item(KIND_BYTE, byte_t'($urandom_range(0, 255)));
			end else begin
				n_lines = $urandom_range(0, 5);
				for (int l = 0; l < n_lines; l++) begin
					build_line();
					foreach (line_buf[i]) begin
						// mode flip inside a document
						if ($urandom_range(0, 79) == 0) begin
							set_mode(!doc_mode_q);
						end
						push_item(KIND_BYTE, line_buf[i]);
					end
					if (l != n_lines - 1 || $urandom_range(0, 2) != 0) begin
						push_item(KIND_BYTE, CH_LF);
					end
				end
			end
			push_item(KIND_END, byte_t'($urandom_range(0, 255)));
		end

		s_axis_tvalid <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_document_feature_counter OK");
		end else begin
			$display("tb_document_feature_counter NOT OK");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_document_feature_counter NOT OK");
		$finish;
	end

endmodule
